// ----- design/fskg_pkg.sv -----
// ----------------------------------------------------------------------------
// fskg_pkg: shared constants, types and functions for the key generator
// SHA-1 initial value, round constants, round functions and index widths.
// ----------------------------------------------------------------------------
package fskg_pkg;

    localparam int unsigned C_WORD_W      = 32;
    localparam int unsigned C_KEY_WORDS   = 5;
    localparam int unsigned C_BLOCK_WORDS = 16;
    localparam int unsigned C_ROUNDS      = 80;
    localparam int unsigned C_OUT_WORDS   = 2 * C_KEY_WORDS;

    localparam int unsigned C_KEY_IDX_W   = $clog2(C_KEY_WORDS);
    localparam int unsigned C_SCHED_AW    = $clog2(C_BLOCK_WORDS);
    localparam int unsigned C_ROUND_W     = $clog2(C_ROUNDS + 1);
    localparam int unsigned C_OUT_IDX_W   = $clog2(C_OUT_WORDS + 1);

    typedef logic [C_WORD_W-1:0] t_word;

    localparam t_word C_IV [C_KEY_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // rotate left by a fixed, nonzero amount
    function automatic t_word f_rotl(input t_word x, input int unsigned n);
        return (x << n) | (x >> (C_WORD_W - n));
    endfunction

    // round function, selected by the round number
    function automatic t_word f_mix(input logic [C_ROUND_W-1:0] t,
                                    input t_word b, input t_word c, input t_word d);
        t_word f;
        if (t < C_ROUND_W'(20)) begin
            f = (b & c) | (~b & d);
        end else if (t < C_ROUND_W'(40)) begin
            f = b ^ c ^ d;
        end else if (t < C_ROUND_W'(60)) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic t_word f_rconst(input logic [C_ROUND_W-1:0] t);
        t_word k;
        if (t < C_ROUND_W'(20)) begin
            k = 32'h5A827999;
        end else if (t < C_ROUND_W'(40)) begin
            k = 32'h6ED9EBA1;
        end else if (t < C_ROUND_W'(60)) begin
            k = 32'h8F1BBCDC;
        end else begin
            k = 32'hCA62C1D6;
        end
        return k;
    endfunction

endpackage

// ----- design/fips186_sha1_key_generator.sv -----
// ----------------------------------------------------------------------------
// fips186_sha1_key_generator: two-round SHA-1 based key generator
// Collects a 160-bit key, derives x0 and x1 by two SHA-1 compressions and
// emits both as ten 32-bit words.
// ----------------------------------------------------------------------------
//
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  key     | i_key_valid, o_key_stall, i_key_word,      | in
//          | i_key_last                                 |
//  out     | o_out_valid, i_out_stall, o_out_word,      | out
//          | o_out_last                                 |
//
// A key word without the last flag is taken and shifted into the key
// register. A word with the last flag starts a compression for x0
// (load of the sixteen-word schedule memory, then 80 rounds, each read in
// two phases from the two-read-port schedule memory), a word-serial xkey
// add, a second compression for x1, then ten output words at one per cycle
// when the sink does not stall. The key channel stalls for that whole span.
// Reset is synchronous and active low; it clears the key register to zero.
// ----------------------------------------------------------------------------
module fips186_sha1_key_generator (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_key_valid,
    output logic                    o_key_stall,
    input  logic [31:0]             i_key_word,
    input  logic                    i_key_last,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [31:0]             o_out_word,
    output logic                    o_out_last
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_HASH0 = 5'b00010,
        S_ADD   = 5'b00100,
        S_HASH1 = 5'b01000,
        S_EMIT  = 5'b10000
    } t_top_state;

    t_top_state                         r_state;
    fskg_pkg::t_word                    r_key  [fskg_pkg::C_KEY_WORDS];
    fskg_pkg::t_word                    r_x0   [fskg_pkg::C_KEY_WORDS];
    fskg_pkg::t_word                    r_xkey [fskg_pkg::C_KEY_WORDS];
    logic                               r_carry;
    logic [fskg_pkg::C_KEY_IDX_W-1:0]   r_aidx;
    logic [fskg_pkg::C_OUT_IDX_W-1:0]   r_oidx;
    logic                               r_start;
    logic                               r_ovalid;
    fskg_pkg::t_word                    r_oword;
    logic                               r_olast;

    logic                               key_accept;
    logic                               slot_free;
    logic [fskg_pkg::C_WORD_W:0]        add_sum;
    fskg_pkg::t_word                    core_msg [fskg_pkg::C_KEY_WORDS];
    fskg_pkg::t_word                    core_dig [fskg_pkg::C_KEY_WORDS];
    logic                               core_done;
    fskg_pkg::t_word                    sel_word;

    fskg_sha1_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_msg   (core_msg),
        .o_done  (core_done),
        .o_dig   (core_dig)
    );

    // take key words only while idle
    assign o_key_stall = (r_state != S_IDLE);
    assign key_accept  = i_key_valid && !o_key_stall;
    assign slot_free   = !r_ovalid || !i_out_stall;

    // feed the core the key for x0, then xkey for x1; both hold while it runs
    always_comb begin
        for (int i = 0; i < fskg_pkg::C_KEY_WORDS; i++) begin
            core_msg[i] = (r_state == S_HASH1) ? r_xkey[i] : r_key[i];
        end
    end

    // one 32-bit word of key + 1 + x0 per cycle, least significant first
    assign add_sum = {1'b0, r_key[r_aidx]} + {1'b0, r_x0[r_aidx]}
                   + {{fskg_pkg::C_WORD_W{1'b0}}, r_carry};

    // words 0 to 4 come from x0, words 5 to 9 from the core's last digest
    always_comb begin
        if (r_oidx < fskg_pkg::C_OUT_IDX_W'(fskg_pkg::C_KEY_WORDS)) begin
            sel_word = r_x0[r_oidx[fskg_pkg::C_KEY_IDX_W-1:0]];
        end else begin
            sel_word = core_dig[fskg_pkg::C_KEY_IDX_W'(
                r_oidx - fskg_pkg::C_OUT_IDX_W'(fskg_pkg::C_KEY_WORDS))];
        end
    end

    // key shift register: oldest, most significant word at entry 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fskg_pkg::C_KEY_WORDS; i++) begin
                r_key[i] <= '0;
            end
        end else if (key_accept) begin
            for (int i = 0; i < fskg_pkg::C_KEY_WORDS - 1; i++) begin
                r_key[i] <= r_key[i + 1];
            end
            r_key[fskg_pkg::C_KEY_WORDS - 1] <= i_key_word;
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_start  <= 1'b0;
            r_carry  <= 1'b0;
            r_aidx   <= '0;
            r_oidx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (key_accept && i_key_last) begin
                        r_start <= 1'b1;
                        r_state <= S_HASH0;
                    end
                end
                S_HASH0: begin
                    if (core_done) begin
                        r_aidx  <= fskg_pkg::C_KEY_IDX_W'(fskg_pkg::C_KEY_WORDS - 1);
                        r_carry <= 1'b1;
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_carry <= add_sum[fskg_pkg::C_WORD_W];
                    r_aidx  <= r_aidx - 1'b1;
                    if (r_aidx == '0) begin
                        r_start <= 1'b1;
                        r_state <= S_HASH1;
                    end
                end
                S_HASH1: begin
                    if (core_done) begin
                        r_oidx  <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        if (r_oidx == fskg_pkg::C_OUT_IDX_W'(fskg_pkg::C_OUT_WORDS)) begin
                            // last word gone: release the key channel
                            r_state <= S_IDLE;
                        end else begin
                            r_ovalid <= 1'b1;
                            r_oidx   <= r_oidx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers: x0 capture, xkey words, output word
    always_ff @(posedge i_clk) begin
        if (r_state == S_HASH0 && core_done) begin
            r_x0 <= core_dig;
        end
        if (r_state == S_ADD) begin
            r_xkey[r_aidx] <= add_sum[fskg_pkg::C_WORD_W-1:0];
        end
        if (r_state == S_EMIT && slot_free
                && r_oidx != fskg_pkg::C_OUT_IDX_W'(fskg_pkg::C_OUT_WORDS)) begin
            r_oword <= sel_word;
            r_olast <= (r_oidx == fskg_pkg::C_OUT_IDX_W'(fskg_pkg::C_OUT_WORDS - 1));
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;
    assign o_out_last  = r_olast;

endmodule

// ----- design/fskg_sched_ram.sv -----
// ----------------------------------------------------------------------------
// fskg_sched_ram: message schedule memory
// Sixteen words, one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module fskg_sched_ram (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [fskg_pkg::C_SCHED_AW-1:0]    i_waddr,
    input  fskg_pkg::t_word                    i_wdata,
    input  logic [fskg_pkg::C_SCHED_AW-1:0]    i_raddr0,
    input  logic [fskg_pkg::C_SCHED_AW-1:0]    i_raddr1,
    output fskg_pkg::t_word                    o_rdata0,
    output fskg_pkg::t_word                    o_rdata1
);

    fskg_pkg::t_word r_mem [fskg_pkg::C_BLOCK_WORDS];
    fskg_pkg::t_word r_rd0;
    fskg_pkg::t_word r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd0 <= r_mem[i_raddr0];
        r_rd1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rd0;
    assign o_rdata1 = r_rd1;

endmodule

// ----- design/fskg_sha1_core.sv -----
// ----------------------------------------------------------------------------
// fskg_sha1_core: SHA-1 compression of one zero-padded block
// Loads five message words and eleven zeros into the schedule memory, runs
// eighty rounds, each read in two phases, and adds the initial value.
// ----------------------------------------------------------------------------
module fskg_sha1_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  fskg_pkg::t_word i_msg [fskg_pkg::C_KEY_WORDS],
    output logic            o_done,
    output fskg_pkg::t_word o_dig [fskg_pkg::C_KEY_WORDS]
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOAD   = 4'b0010,
        S_ROUND  = 4'b0100,
        S_FINISH = 4'b1000
    } t_core_state;

    t_core_state                          r_state;
    logic [fskg_pkg::C_SCHED_AW-1:0]      r_cnt;
    logic [fskg_pkg::C_ROUND_W-1:0]       r_t;
    logic [fskg_pkg::C_ROUND_W-1:0]       r_ct;
    logic                                 r_ph;
    logic                                 r_pend;
    logic                                 r_done;
    fskg_pkg::t_word                      r_wa;
    fskg_pkg::t_word                      r_st  [fskg_pkg::C_KEY_WORDS];
    fskg_pkg::t_word                      r_dig [fskg_pkg::C_KEY_WORDS];

    logic                                 mem_we;
    logic [fskg_pkg::C_SCHED_AW-1:0]      mem_waddr;
    fskg_pkg::t_word                      mem_wdata;
    logic [fskg_pkg::C_SCHED_AW-1:0]      mem_ra0;
    logic [fskg_pkg::C_SCHED_AW-1:0]      mem_ra1;
    fskg_pkg::t_word                      mem_rd0;
    fskg_pkg::t_word                      mem_rd1;

    logic                                 round_fire;
    fskg_pkg::t_word                      w_new;
    fskg_pkg::t_word                      n_a;

    fskg_sched_ram u_sched (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wdata  (mem_wdata),
        .i_raddr0 (mem_ra0),
        .i_raddr1 (mem_ra1),
        .o_rdata0 (mem_rd0),
        .o_rdata1 (mem_rd1)
    );

    // phase 0 reads taps t and t+2, phase 1 reads taps t+8 and t+13;
    // round t is finished in the next phase 0 while round t+1 is read
    assign round_fire = (r_state == S_ROUND) && !r_ph && r_pend;

    always_comb begin
        mem_ra0 = r_ph ? (r_t[fskg_pkg::C_SCHED_AW-1:0] + 4'd8)
                       :  r_t[fskg_pkg::C_SCHED_AW-1:0];
        mem_ra1 = r_ph ? (r_t[fskg_pkg::C_SCHED_AW-1:0] + 4'd13)
                       : (r_t[fskg_pkg::C_SCHED_AW-1:0] + 4'd2);
    end

    always_comb begin
        if (r_ct < fskg_pkg::C_ROUND_W'(fskg_pkg::C_BLOCK_WORDS)) begin
            w_new = r_wa;
        end else begin
            w_new = fskg_pkg::f_rotl(r_wa ^ mem_rd0 ^ mem_rd1, 1);
        end
        n_a = fskg_pkg::f_rotl(r_st[0], 5)
            + fskg_pkg::f_mix(r_ct, r_st[1], r_st[2], r_st[3])
            + r_st[4] + fskg_pkg::f_rconst(r_ct) + w_new;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cnt;
        mem_wdata = '0;
        if (r_state == S_LOAD) begin
            mem_we = 1'b1;
            if (r_cnt < fskg_pkg::C_SCHED_AW'(fskg_pkg::C_KEY_WORDS)) begin
                mem_wdata = i_msg[r_cnt[fskg_pkg::C_KEY_IDX_W-1:0]];
            end
        end else if (round_fire) begin
            mem_we    = 1'b1;
            mem_waddr = r_ct[fskg_pkg::C_SCHED_AW-1:0];
            mem_wdata = w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_t     <= '0;
            r_ct    <= '0;
            r_ph    <= 1'b0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cnt   <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == fskg_pkg::C_SCHED_AW'(fskg_pkg::C_BLOCK_WORDS - 1)) begin
                        r_t     <= '0;
                        r_ph    <= 1'b0;
                        r_pend  <= 1'b0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    if (!r_ph) begin
                        r_pend <= 1'b0;
                        if (r_t == fskg_pkg::C_ROUND_W'(fskg_pkg::C_ROUNDS)) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_ph <= 1'b1;
                        end
                    end else begin
                        r_ct   <= r_t;
                        r_t    <= r_t + 1'b1;
                        r_pend <= 1'b1;
                        r_ph   <= 1'b0;
                    end
                end
                S_FINISH: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // working variables, partial schedule word and digest
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            for (int i = 0; i < fskg_pkg::C_KEY_WORDS; i++) begin
                r_st[i] <= fskg_pkg::C_IV[i];
            end
        end
        if (r_state == S_ROUND && r_ph) begin
            if (r_t < fskg_pkg::C_ROUND_W'(fskg_pkg::C_BLOCK_WORDS)) begin
                r_wa <= mem_rd0;
            end else begin
                r_wa <= mem_rd0 ^ mem_rd1;
            end
        end
        if (round_fire) begin
            r_st[4] <= r_st[3];
            r_st[3] <= r_st[2];
            r_st[2] <= fskg_pkg::f_rotl(r_st[1], 30);
            r_st[1] <= r_st[0];
            r_st[0] <= n_a;
        end
        if (r_state == S_FINISH) begin
            for (int i = 0; i < fskg_pkg::C_KEY_WORDS; i++) begin
                r_dig[i] <= fskg_pkg::C_IV[i] + r_st[i];
            end
        end
    end

    assign o_done = r_done;
    assign o_dig  = r_dig;

endmodule

// ----- tb/fips186_sha1_key_checker.sv -----
// ----------------------------------------------------------------------------
// fips186_sha1_key_checker: output predictor and scoreboard for the generator
// Tracks the key shift register from accepted key words and, on each word
// flagged last, computes x0 and x1 with its own SHA-1 compression. It then
// compares every accepted output word with the oldest predicted word.
// ----------------------------------------------------------------------------
module fips186_sha1_key_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_key_valid,
    input  logic            i_key_stall,
    input  fskg_pkg::t_word i_key_word,
    input  logic            i_key_last,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  fskg_pkg::t_word i_out_word,
    input  logic            i_out_last,
    output int              o_errors,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_REPORTS = 10;

    localparam fskg_pkg::t_word K_CHOOSE   = 32'h5A827999;
    localparam fskg_pkg::t_word K_PARITY_A = 32'h6ED9EBA1;
    localparam fskg_pkg::t_word K_MAJORITY = 32'h8F1BBCDC;
    localparam fskg_pkg::t_word K_PARITY_B = 32'hCA62C1D6;

    typedef struct packed {
        fskg_pkg::t_word word;
        logic            last;
    } t_gen_word;

    t_gen_word    predicted_words [$];
    logic [159:0] key_shift   = '0;
    int           error_count = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // Bare SHA-1 compression from the initial value of one block holding
    // the 160-bit message followed by zeros; no length padding.
    function automatic logic [159:0] sha1_block(input logic [159:0] msg);
        fskg_pkg::t_word sched [16];
        fskg_pkg::t_word a, b, c, d, e, f, k, w, tmp;
        int              t;
        for (t = 0; t < 16; t++) begin
            sched[t] = (t < fskg_pkg::C_KEY_WORDS) ? msg[159 - 32*t -: 32] : '0;
        end
        a = fskg_pkg::C_IV[0];
        b = fskg_pkg::C_IV[1];
        c = fskg_pkg::C_IV[2];
        d = fskg_pkg::C_IV[3];
        e = fskg_pkg::C_IV[4];
        for (t = 0; t < 80; t++) begin
            if (t < 16) begin
                w = sched[t];
            end else begin
                w = sched[(t + 13) % 16] ^ sched[(t + 8) % 16] ^
                    sched[(t + 2) % 16] ^ sched[t % 16];
                w = {w[30:0], w[31]};
                sched[t % 16] = w;
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K_CHOOSE;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_PARITY_A;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJORITY;
            end else begin
                f = b ^ c ^ d;
                k = K_PARITY_B;
            end
            tmp = {a[26:0], a[31:27]} + f + e + k + w;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        return {a + fskg_pkg::C_IV[0], b + fskg_pkg::C_IV[1], c + fskg_pkg::C_IV[2],
                d + fskg_pkg::C_IV[3], e + fskg_pkg::C_IV[4]};
    endfunction

    always @(posedge i_clk) begin : watch
        logic [159:0] x0, x1, xkey, both;
        t_gen_word    head;
        int           idx;
        if (!i_rst_n) begin
            key_shift = '0;
            predicted_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (predicted_words.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%t: unexpected output word %h last %b",
                                 $realtime, i_out_word, i_out_last);
                    end
                end else begin
                    idx  = (fskg_pkg::C_OUT_WORDS
                            - predicted_words.size() % fskg_pkg::C_OUT_WORDS)
                           % fskg_pkg::C_OUT_WORDS;
                    head = predicted_words.pop_front();
                    if (head.word !== i_out_word || head.last !== i_out_last) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $display("%t: output word %0d: expected %h last %b, got %h last %b",
                                     $realtime, idx, head.word, head.last,
                                     i_out_word, i_out_last);
                        end
                    end
                end
            end
            if (i_key_valid && !i_key_stall) begin
                key_shift = {key_shift[127:0], i_key_word};
                if (i_key_last) begin
                    x0   = sha1_block(key_shift);
                    xkey = key_shift + x0 + 160'd1;
                    x1   = sha1_block(xkey);
                    for (idx = 0; idx < fskg_pkg::C_OUT_WORDS; idx++) begin
                        both = (idx < fskg_pkg::C_KEY_WORDS) ? x0 : x1;
                        head.word = both[159 - 32*(idx % fskg_pkg::C_KEY_WORDS) -: 32];
                        head.last = (idx == fskg_pkg::C_OUT_WORDS - 1);
                        predicted_words.push_back(head);
                    end
                end
            end
        end
        o_errors  = error_count;
        o_pending = predicted_words.size();
    end

endmodule

// ----- tb/tb_fips186_sha1_key_generator.sv -----
// ----------------------------------------------------------------------------
// tb_fips186_sha1_key_generator: testbench for the two-round key generator
// Feeds key words with random gaps and stalls the output side at random.
// Directed keys cover zero and all-ones keys, early and late last flags and
// an xkey with a leading zero byte; random keys follow. A separate checker
// predicts x0 and x1 and compares them word by word.
// ----------------------------------------------------------------------------
module tb_fips186_sha1_key_generator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 106;
    localparam int CYCLE_LIMIT  = 1000000;
    // idle cycles after the checker has drained
    localparam int TAIL_CYCLES  = 400;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            key_valid;
    logic            key_stall;
    fskg_pkg::t_word key_word;
    logic            key_last;
    logic            out_valid;
    logic            out_stall = 1'b0;
    fskg_pkg::t_word out_word;
    logic            out_last;

    int    errors;
    int    pending;
    int    words_sent = 0;
    int    cycles     = 0;
    logic  no_gaps    = 1'b0;

    always #5 clk = ~clk;

    fips186_sha1_key_generator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_key_valid (key_valid),
        .o_key_stall (key_stall),
        .i_key_word  (key_word),
        .i_key_last  (key_last),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .o_out_last  (out_last)
    );

    fips186_sha1_key_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_key_valid (key_valid),
        .i_key_stall (key_stall),
        .i_key_word  (key_word),
        .i_key_last  (key_last),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_word  (out_word),
        .i_out_last  (out_last),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Stop a hung run.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Output back-pressure: free runs, short stalls and the odd long one.
    // Run lengths are drawn at random, so stalls hit output words at random points.
    int stall_left = 0;
    always @(posedge clk) begin : sink_stall
        int r;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(1, 20);
            end else if (r < 90) begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end else begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Bias toward the field extremes so every bit flips both ways.
    function automatic fskg_pkg::t_word rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Offer one word, hold it until accepted, then idle for a random gap.
    // With no gap, valid simply stays high for the next word.
    task automatic send_word(input fskg_pkg::t_word w, input logic last);
        int gap;
        key_valid <= 1'b1;
        key_word  <= w;
        key_last  <= last;
        do @(posedge clk); while (key_stall);
        words_sent++;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            key_valid <= 1'b0;
            key_word  <= $urandom;
            key_last  <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Send a whole 160-bit key, most significant word first, last on word five.
    task automatic send_key(input logic [159:0] k);
        int i;
        for (i = 0; i < fskg_pkg::C_KEY_WORDS; i++) begin
            send_word(k[159 - 32*i -: 32], i == fskg_pkg::C_KEY_WORDS - 1);
        end
    endtask

    initial begin : stimulus
        logic [159:0] lz_key;
        logic [159:0] lz_xkey;
        int           directed_words;
        int           n;
        int           i;
        int           r;

        rst_n     <= 1'b0;
        key_valid <= 1'b0;
        key_word  <= '0;
        key_last  <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Early last right after reset: the three older words are still zero.
        send_word($urandom, 1'b0);
        send_word($urandom, 1'b1);

        // Zero key, then all-ones key, which carries out of bit 160.
        send_key('0);
        send_key('1);

        // Find a key whose xkey starts with a zero byte; it must stay 20 bytes.
        do begin
            lz_key  = {$urandom, $urandom, $urandom, $urandom, $urandom};
            lz_xkey = lz_key + u_checker.sha1_block(lz_key) + 160'd1;
        end while (lz_xkey[159:152] != 8'h00);
        send_key(lz_key);

        // Late last: seven words, only the five newest count.
        for (i = 0; i < 7; i++) begin
            send_word($urandom, i == 6);
        end
        directed_words = words_sent;

        // Random part: mostly full keys, some broken runs and stray words.
        while (words_sent < directed_words + RANDOM_WORDS) begin
            no_gaps = ($urandom_range(0, 5) == 0);
            r = $urandom_range(0, 99);
            if (r < 80) begin
                send_key({rand_word(), rand_word(), rand_word(), rand_word(), rand_word()});
            end else if (r < 92) begin
                n = $urandom_range(1, 9);
                for (i = 0; i < n; i++) begin
                    send_word(rand_word(), i == n - 1);
                end
            end else begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++) begin
                    send_word(rand_word(), 1'b0);
                end
            end
        end
        key_valid <= 1'b0;

        // Drain: sample the checker away from the active edge.
        do @(negedge clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);

        if (errors == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
